// ===== hdl/mrmb_pkg.sv =====
// shared types, constants and lookup functions of the rate-matrix builder
package mrmb_pkg;

    localparam int MAX_STATES = 8;
    localparam int MAX_EDGES = 16;
    localparam int CORDIC_STEPS = 18;

    localparam logic [1:0] CMD_LOAD_NODE = 2'd0;
    localparam logic [1:0] CMD_LOAD_EDGE = 2'd1;
    localparam logic [1:0] CMD_EVALUATE = 2'd2;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_EDGE_COUNT = 2'd1;
    localparam logic [1:0] REG_GATE_OFFSET = 2'd2;
    localparam logic [1:0] REG_GATE_SLOPE = 2'd3;

    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic [14:0] LN2_HALF = 15'd22713;
    // floor(2^16 / ln2), the quotient estimate is exact or one low
    localparam logic [16:0] LN2_RECIP = 17'd94548;
    // 18 * ln2 + ln2 / 2, keeps the range-reduction dividend positive
    localparam logic signed [27:0] EXP_BIAS_SUM = 28'sd840381;
    localparam logic signed [27:0] EXP_HI = 28'sd1441792;
    localparam logic signed [27:0] EXP_LO = -28'sd786432;
    localparam logic [6:0] EXP_BIAS = 7'd18;
    localparam logic [19:0] TANH_CLAMP = 20'd524288;
    localparam logic signed [31:0] CORDIC_X0 = 32'sd20258439;
    localparam logic [46:0] EXP_SAT = {47{1'b1}};

    typedef struct packed {
        logic signed [23:0] coef_fixed;
        logic signed [23:0] coef_gated;
    } node_entry_t;

    typedef struct packed {
        logic [2:0] from_node;
        logic [2:0] to_node;
        logic signed [23:0] coef_fixed;
        logic signed [23:0] coef_gated;
    } edge_entry_t;

    function automatic logic [4:0] step_shift(input logic [4:0] j);
        logic [4:0] s;
        case (j)
            5'd0: s = 5'd1;
            5'd1: s = 5'd2;
            5'd2: s = 5'd3;
            5'd3: s = 5'd4;
            5'd4: s = 5'd4;
            5'd5: s = 5'd5;
            5'd6: s = 5'd6;
            5'd7: s = 5'd7;
            5'd8: s = 5'd8;
            5'd9: s = 5'd9;
            5'd10: s = 5'd10;
            5'd11: s = 5'd11;
            5'd12: s = 5'd12;
            5'd13: s = 5'd13;
            5'd14: s = 5'd13;
            5'd15: s = 5'd14;
            5'd16: s = 5'd15;
            default: s = 5'd16;
        endcase
        return s;
    endfunction

    function automatic logic [23:0] atanh_q24(input logic [4:0] s);
        logic [23:0] v;
        case (s)
            5'd1: v = 24'd9215828;
            5'd2: v = 24'd4285116;
            5'd3: v = 24'd2108178;
            5'd4: v = 24'd1049945;
            5'd5: v = 24'd524459;
            5'd6: v = 24'd262165;
            5'd7: v = 24'd131075;
            5'd8: v = 24'd65536;
            5'd9: v = 24'd32768;
            5'd10: v = 24'd16384;
            5'd11: v = 24'd8192;
            5'd12: v = 24'd4096;
            5'd13: v = 24'd2048;
            5'd14: v = 24'd1024;
            5'd15: v = 24'd512;
            5'd16: v = 24'd256;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/markov_rate_matrix_builder.sv =====
// rate-matrix builder: tables, sequencer, shared divider, cordic exp and matrix memory
//
// usage:
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes node_count,
//   edge_count, gate_offset and gate_slope; ready is always high, write only when idle
//   input channel (in_valid/in_stall) takes one command request: load node, load edge
//   or evaluate; loads finish in the accept cycle, in_stall is high while evaluating
//   output channel (out_valid/out_stall) gives n*n entries, n = clamped node_count,
//   row by row; last marks the final one; a stalled entry holds until taken
// evaluate sequence:
//   an evaluate clears the 64-entry matrix memory, runs the gating value
//   (two 34-step divisions and one exp), then per edge a forward and a
//   backward exp and the matrix updates; one exp in range is a reciprocal
//   range reduction, 18 cordic steps and a final shift; out of range the
//   result saturates or is zero; divisions share one restoring divider,
//   exp steps one cordic stage; each matrix entry is then read out and
//   held while the output stalls
// reset:
//   registers return to 8, 1, 0, 256; tables hold garbage until loaded
module markov_rate_matrix_builder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [3:0]         slot,
    input  logic [2:0]         from_node,
    input  logic [2:0]         to_node,
    input  logic signed [23:0] coef_fixed,
    input  logic signed [23:0] coef_gated,
    input  logic signed [15:0] voltage,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         row,
    output logic [2:0]         col,
    output logic signed [47:0] rate,
    output logic               last
);

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_GQ, S_GQ2, S_GT, S_GG,
        S_E0, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6,
        S_A0, S_A1, S_O0, S_O1, S_O2,
        S_X0, S_XR, S_X1, S_X2, S_X3, S_DIV
    } state_t;

    state_t state_reg, div_ret_reg, exp_ret_reg;

    logic [3:0]         node_count_reg;
    logic [4:0]         edge_count_reg;
    logic signed [15:0] gate_offset_reg;
    logic [14:0]        gate_slope_reg;

    mrmb_pkg::node_entry_t node_mem [mrmb_pkg::MAX_STATES];
    mrmb_pkg::edge_entry_t edge_mem [mrmb_pkg::MAX_EDGES];
    logic signed [47:0]    rate_mem [mrmb_pkg::MAX_STATES * mrmb_pkg::MAX_STATES];

    mrmb_pkg::node_entry_t node_rd, na_reg;
    mrmb_pkg::edge_entry_t edge_rd;
    logic signed [47:0]    rate_rd;
    logic [2:0]            node_addr;
    logic                  rate_we;
    logic [5:0]            rate_waddr, rate_raddr;
    logic signed [47:0]    rate_wdata;

    logic [6:0]         clr_cnt_reg;
    logic signed [16:0] num_reg;
    logic [16:0]        mag;
    logic [14:0]        slope;
    logic [33:0]        div_num_reg;
    logic [17:0]        div_den_reg;
    logic [17:0]        rem_reg;
    logic [33:0]        quo_reg;
    logic [5:0]         div_cnt_reg;
    logic [18:0]        trial;
    logic signed [17:0] g_reg;
    logic [4:0]         idx_reg;
    logic [4:0]         ne;
    logic [3:0]         n;
    logic signed [24:0] d0_reg, d1_reg;
    logic               dir_reg;
    logic signed [25:0] s0_reg;
    logic signed [25:0] s0_sum, s1_sum;
    logic signed [43:0] prod_reg;
    logic signed [44:0] arg_sum;
    logic signed [27:0] z_reg, z_bias;
    logic [43:0]        red_prod;
    logic signed [27:0] red_rem;
    logic [46:0]        exp_res_reg, fw_reg, bw_reg;
    logic [1:0]         upd_reg;
    logic signed [6:0]  k_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [27:0] a_reg;
    logic [4:0]         j_reg, sh_amt;
    logic [23:0]        at_val;
    logic signed [32:0] e_sum;
    logic [31:0]        e_pos;
    logic signed [7:0]  sh;
    logic [4:0]         rsh;
    logic [48:0]        e_shift;
    logic [16:0]        t_val;
    logic [19:0]        q_val;
    logic [2:0]         r_reg, c_reg;
    logic [2:0]         acc_row, acc_col;
    logic signed [48:0] acc_delta, acc_sum;
    logic signed [17:0] rem_off;

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 4'd8;
            edge_count_reg <= 5'd1;
            gate_offset_reg <= 16'sd0;
            gate_slope_reg <= 15'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mrmb_pkg::REG_NODE_COUNT: node_count_reg <= cfg_data[3:0];
                mrmb_pkg::REG_EDGE_COUNT: edge_count_reg <= cfg_data[4:0];
                mrmb_pkg::REG_GATE_OFFSET: gate_offset_reg <= cfg_data;
                mrmb_pkg::REG_GATE_SLOPE: gate_slope_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        n = (node_count_reg == 4'd0) ? 4'd1 :
            (node_count_reg > 4'd8) ? 4'd8 : node_count_reg;
        ne = (edge_count_reg > 5'd16) ? 5'd16 : edge_count_reg;
        slope = (gate_slope_reg == 15'd0) ? 15'd1 : gate_slope_reg;
        mag = num_reg[16] ? 17'(-num_reg) : 17'(num_reg);
        trial = {rem_reg, div_num_reg[33]};
        q_val = (quo_reg > 34'(mrmb_pkg::TANH_CLAMP)) ? mrmb_pkg::TANH_CLAMP : quo_reg[19:0];
        t_val = (exp_res_reg > 47'(mrmb_pkg::Q16_ONE)) ? mrmb_pkg::Q16_ONE : exp_res_reg[16:0];
        s0_sum = dir_reg ? (26'(edge_rd.coef_fixed) - 26'(d0_reg))
                         : (26'(edge_rd.coef_fixed) + 26'(d0_reg));
        s1_sum = dir_reg ? (26'(edge_rd.coef_gated) - 26'(d1_reg))
                         : (26'(edge_rd.coef_gated) + 26'(d1_reg));
        arg_sum = (45'(s0_reg) <<< 16) + 45'(prod_reg) + 45'sd65536;
        z_bias = z_reg + mrmb_pkg::EXP_BIAS_SUM;
        red_prod = 44'(z_bias[26:0]) * 44'(mrmb_pkg::LN2_RECIP);
        red_rem = z_bias - $signed(28'(quo_reg[5:0]) * 28'(mrmb_pkg::LN2_Q16));
        rem_off = $signed({2'b00, rem_reg[15:0]}) - $signed({3'b000, mrmb_pkg::LN2_HALF});
        sh_amt = mrmb_pkg::step_shift(j_reg);
        at_val = mrmb_pkg::atanh_q24(sh_amt);
        e_sum = 33'(x_reg) + 33'(y_reg);
        e_pos = e_sum[32] ? 32'd0 : e_sum[31:0];
        sh = 8'(k_reg) - 8'sd8;
        rsh = 5'(-sh);
        if (!sh[7])
            e_shift = {17'd0, e_pos} << sh[4:0];
        else
            e_shift = ({17'd0, e_pos} + (49'd1 << (rsh - 5'd1))) >> rsh;
        case (upd_reg)
            2'd0:
            begin
                acc_row = edge_rd.from_node; acc_col = edge_rd.from_node;
                acc_delta = -49'(fw_reg);
            end
            2'd1:
            begin
                acc_row = edge_rd.to_node; acc_col = edge_rd.to_node;
                acc_delta = -49'(bw_reg);
            end
            2'd2:
            begin
                acc_row = edge_rd.to_node; acc_col = edge_rd.from_node;
                acc_delta = 49'(fw_reg);
            end
            default:
            begin
                acc_row = edge_rd.from_node; acc_col = edge_rd.to_node;
                acc_delta = 49'(bw_reg);
            end
        endcase
        acc_sum = 49'(rate_rd) + acc_delta;
        node_addr = (state_reg == S_E1) ? edge_rd.from_node : edge_rd.to_node;
        rate_we = 1'b0;
        rate_waddr = {acc_row, acc_col};
        rate_wdata = 48'sd0;
        rate_raddr = {acc_row, acc_col};
        case (state_reg)
            S_CLR:
            begin
                rate_we = 1'b1;
                rate_waddr = clr_cnt_reg[5:0];
            end
            S_A1:
            begin
                rate_we = 1'b1;
                if (acc_sum > 49'sh0_7FFF_FFFF_FFFF)
                    rate_wdata = 48'sh7FFF_FFFF_FFFF;
                else if (acc_sum < -49'sh0_8000_0000_0000)
                    rate_wdata = 48'sh8000_0000_0000;
                else
                    rate_wdata = acc_sum[47:0];
            end
            S_O0: rate_raddr = {r_reg, c_reg};
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall && command == mrmb_pkg::CMD_LOAD_NODE && !slot[3])
            node_mem[slot[2:0]] <= '{coef_fixed: coef_fixed, coef_gated: coef_gated};
        if (in_valid && !in_stall && command == mrmb_pkg::CMD_LOAD_EDGE)
            edge_mem[slot] <= '{from_node: from_node, to_node: to_node,
                                coef_fixed: coef_fixed, coef_gated: coef_gated};
        if (rate_we)
            rate_mem[rate_waddr] <= rate_wdata;
        node_rd <= node_mem[node_addr];
        edge_rd <= edge_mem[idx_reg[3:0]];
        rate_rd <= rate_mem[rate_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            div_ret_reg <= S_IDLE;
            exp_ret_reg <= S_IDLE;
            out_valid <= 1'b0;
            clr_cnt_reg <= 7'd0;
            div_cnt_reg <= 6'd0;
            idx_reg <= 5'd0;
            j_reg <= 5'd0;
            upd_reg <= 2'd0;
            dir_reg <= 1'b0;
            r_reg <= 3'd0;
            c_reg <= 3'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && command == mrmb_pkg::CMD_EVALUATE)
                    begin
                        num_reg <= 17'(voltage) + 17'(gate_offset_reg);
                        clr_cnt_reg <= 7'd0;
                        state_reg <= S_CLR;
                    end
                end
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 7'd1;
                    if (clr_cnt_reg[5:0] == 6'd63)
                        state_reg <= S_GQ;
                end
                S_GQ:
                begin
                    div_num_reg <= {1'b0, mag, 16'd0} + 34'(slope >> 1);
                    div_den_reg <= 18'(slope);
                    rem_reg <= 18'd0;
                    div_cnt_reg <= 6'd0;
                    div_ret_reg <= S_GQ2;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (trial >= 19'(div_den_reg))
                    begin
                        rem_reg <= 18'(trial - 19'(div_den_reg));
                        quo_reg <= {quo_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[17:0];
                        quo_reg <= {quo_reg[32:0], 1'b0};
                    end
                    div_num_reg <= {div_num_reg[32:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd33)
                        state_reg <= div_ret_reg;
                end
                S_GQ2:
                begin
                    z_reg <= -(28'(q_val) <<< 1);
                    exp_ret_reg <= S_GT;
                    state_reg <= S_X0;
                end
                S_GT:
                begin
                    div_num_reg <= ({17'd0, mrmb_pkg::Q16_ONE - t_val} << 16)
                                   + 34'((18'(mrmb_pkg::Q16_ONE) + 18'(t_val)) >> 1);
                    div_den_reg <= 18'(mrmb_pkg::Q16_ONE) + 18'(t_val);
                    rem_reg <= 18'd0;
                    div_cnt_reg <= 6'd0;
                    div_ret_reg <= S_GG;
                    state_reg <= S_DIV;
                end
                S_GG:
                begin
                    g_reg <= num_reg[16] ? -$signed(quo_reg[17:0]) : $signed(quo_reg[17:0]);
                    idx_reg <= 5'd0;
                    state_reg <= S_E0;
                end
                S_E0:
                begin
                    if (idx_reg >= ne)
                    begin
                        r_reg <= 3'd0;
                        c_reg <= 3'd0;
                        state_reg <= S_O0;
                    end
                    else
                        state_reg <= S_E1;
                end
                S_E1: state_reg <= S_E2;
                S_E2:
                begin
                    na_reg <= node_rd;
                    state_reg <= S_E3;
                end
                S_E3:
                begin
                    d0_reg <= 25'(node_rd.coef_fixed) - 25'(na_reg.coef_fixed);
                    d1_reg <= 25'(node_rd.coef_gated) - 25'(na_reg.coef_gated);
                    dir_reg <= 1'b0;
                    state_reg <= S_E4;
                end
                S_E4:
                begin
                    s0_reg <= s0_sum;
                    prod_reg <= 44'(s1_sum) * 44'(g_reg);
                    state_reg <= S_E5;
                end
                S_E5:
                begin
                    z_reg <= arg_sum[44:17];
                    exp_ret_reg <= S_E6;
                    state_reg <= S_X0;
                end
                S_E6:
                begin
                    if (!dir_reg)
                    begin
                        fw_reg <= exp_res_reg;
                        dir_reg <= 1'b1;
                        state_reg <= S_E4;
                    end
                    else
                    begin
                        bw_reg <= exp_res_reg;
                        upd_reg <= 2'd0;
                        state_reg <= S_A0;
                    end
                end
                S_A0: state_reg <= S_A1;
                S_A1:
                begin
                    upd_reg <= upd_reg + 2'd1;
                    if (upd_reg == 2'd3)
                    begin
                        idx_reg <= idx_reg + 5'd1;
                        state_reg <= S_E0;
                    end
                    else
                        state_reg <= S_A0;
                end
                S_O0: state_reg <= S_O1;
                S_O1:
                begin
                    row <= r_reg;
                    col <= c_reg;
                    rate <= rate_rd;
                    last <= (4'(r_reg) == n - 4'd1) && (4'(c_reg) == n - 4'd1);
                    out_valid <= 1'b1;
                    state_reg <= S_O2;
                end
                S_O2:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        if (4'(c_reg) == n - 4'd1)
                        begin
                            c_reg <= 3'd0;
                            r_reg <= r_reg + 3'd1;
                            state_reg <= (4'(r_reg) == n - 4'd1) ? S_IDLE : S_O0;
                        end
                        else
                        begin
                            c_reg <= c_reg + 3'd1;
                            state_reg <= S_O0;
                        end
                    end
                end
                S_X0:
                begin
                    if (z_reg > mrmb_pkg::EXP_HI)
                    begin
                        exp_res_reg <= mrmb_pkg::EXP_SAT;
                        state_reg <= exp_ret_reg;
                    end
                    else if (z_reg < mrmb_pkg::EXP_LO)
                    begin
                        exp_res_reg <= 47'd0;
                        state_reg <= exp_ret_reg;
                    end
                    else
                    begin
                        // range reduction by ln2: reciprocal estimate, then one correction
                        quo_reg <= 34'(red_prod[43:32]);
                        state_reg <= S_XR;
                    end
                end
                S_XR:
                begin
                    if (red_rem >= $signed({12'd0, mrmb_pkg::LN2_Q16}))
                    begin
                        quo_reg <= quo_reg + 34'd1;
                        rem_reg <= 18'(red_rem - $signed({12'd0, mrmb_pkg::LN2_Q16}));
                    end
                    else
                        rem_reg <= 18'(red_rem);
                    state_reg <= S_X1;
                end
                S_X1:
                begin
                    k_reg <= $signed(quo_reg[6:0] - mrmb_pkg::EXP_BIAS);
                    x_reg <= mrmb_pkg::CORDIC_X0;
                    y_reg <= 32'sd0;
                    a_reg <= 28'(rem_off) <<< 8;
                    j_reg <= 5'd0;
                    state_reg <= S_X2;
                end
                S_X2:
                begin
                    if (!a_reg[27])
                    begin
                        x_reg <= x_reg + (y_reg >>> sh_amt);
                        y_reg <= y_reg + (x_reg >>> sh_amt);
                        a_reg <= a_reg - 28'(at_val);
                    end
                    else
                    begin
                        x_reg <= x_reg - (y_reg >>> sh_amt);
                        y_reg <= y_reg - (x_reg >>> sh_amt);
                        a_reg <= a_reg + 28'(at_val);
                    end
                    j_reg <= j_reg + 5'd1;
                    if (j_reg == 5'(mrmb_pkg::CORDIC_STEPS - 1))
                        state_reg <= S_X3;
                end
                S_X3:
                begin
                    exp_res_reg <= (e_shift > 49'(mrmb_pkg::EXP_SAT)) ? mrmb_pkg::EXP_SAT
                                                                      : e_shift[46:0];
                    state_reg <= exp_ret_reg;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
